FILE: hdl/swdfe_pkg.sv
`default_nettype none

package swdfe_pkg;

  // Fixed widths of the link timer and frame fields.
  localparam int unsigned TickW = 16;
  localparam int unsigned SlotW = 9;
  localparam int unsigned ByteW = 8;

  localparam logic [TickW-1:0] TickMax = '1;

  // Bit count at which a sent frame is complete (header, payload, parity).
  localparam logic [3:0] CmdFrameBits  = 4'd5;
  localparam logic [3:0] ByteFrameBits = 4'd10;
  // Last payload bit index of a received frame; the next one is parity.
  localparam logic [3:0] RxLastDataIdx = 4'd8;

  // Configuration register indexes.
  localparam logic [2:0] RegShortLow   = 3'd0;
  localparam logic [2:0] RegLongLow    = 3'd1;
  localparam logic [2:0] RegBitSlot    = 3'd2;
  localparam logic [2:0] RegSampDelay  = 3'd3;
  localparam logic [2:0] RegAckGap     = 3'd4;
  localparam logic [2:0] RegTimeout    = 3'd5;

  // Configuration reset values.
  localparam logic [7:0]       ShortLowRst  = 8'd12;
  localparam logic [7:0]       LongLowRst   = 8'd125;
  localparam logic [SlotW-1:0] BitSlotRst   = 9'd137;
  localparam logic [7:0]       SampDelayRst = 8'd62;
  localparam logic [7:0]       AckGapRst    = 8'd12;
  localparam logic [TickW-1:0] TimeoutRst   = 16'd8000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TXWAIT,
    PH_TXBIT,
    PH_ACKWAIT,
    PH_ACKSAMP,
    PH_RXWAIT,
    PH_RXSAMP,
    PH_GAP
  } phase_e;

  // Command codes double as the frame kind.
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_CMD,
    KIND_BYTE,
    KIND_RX
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NACK,
    ST_TIMEOUT,
    ST_BAD_HDR,
    ST_PARITY
  } status_e;

  typedef struct packed {
    logic [7:0]       short_low;
    logic [7:0]       long_low;
    logic [SlotW-1:0] bit_slot;
    logic [7:0]       samp_delay;
    logic [7:0]       ack_gap;
    logic [TickW-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    kind_e            kind;
    logic [3:0]       bit_idx;
    logic [TickW-1:0] tick;
    logic [8:0]       shift;
    logic             par;
    logic [ByteW-1:0] rx_byte;
    logic             prev_line;
  } state_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy;
    logic             done;
    status_e          status;
    logic [ByteW-1:0] rx_byte;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/single_wire_debug_frame_engine_unit.sv
// Pipeline: an input item is loaded into the input register at its transfer and moves on
// into the result register when that one is free or its result is being taken.
// Throughput: one item per cycle while the output side takes results; while a result
// waits, one more item is held in the input register and then the input stalls.
// Reset (rst_ni low, asynchronous): line state goes idle, all timing registers
// return to their default values, and both pipeline registers are emptied.
`default_nettype none

module single_wire_debug_frame_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // Input stream.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // line_in[0], data_byte[8:1], zero fill
  input  wire logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  // Result stream.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o   // drive_low[0], busy_res[1], done_res[2],
                                            // status[5:3], rx_byte[13:6], zero fill
);

  swdfe_pkg::cfg_t    cfg_q;
  swdfe_pkg::state_t  state_q, state_d;
  swdfe_pkg::result_t res_d, res_q;

  logic       in_valid_q;
  logic [1:0] in_cmd_q;
  logic       in_line_q;
  logic [7:0] in_data_q;
  logic       out_valid_q;
  logic       advance;

  // The buffered item moves into the result register when that one is free.
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_low  <= swdfe_pkg::ShortLowRst;
      cfg_q.long_low   <= swdfe_pkg::LongLowRst;
      cfg_q.bit_slot   <= swdfe_pkg::BitSlotRst;
      cfg_q.samp_delay <= swdfe_pkg::SampDelayRst;
      cfg_q.ack_gap    <= swdfe_pkg::AckGapRst;
      cfg_q.timeout    <= swdfe_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swdfe_pkg::RegShortLow:  cfg_q.short_low  <= cfg_data_i[7:0];
        swdfe_pkg::RegLongLow:   cfg_q.long_low   <= cfg_data_i[7:0];
        swdfe_pkg::RegBitSlot:   cfg_q.bit_slot   <= cfg_data_i[8:0];
        swdfe_pkg::RegSampDelay: cfg_q.samp_delay <= cfg_data_i[7:0];
        swdfe_pkg::RegAckGap:    cfg_q.ack_gap    <= cfg_data_i[7:0];
        swdfe_pkg::RegTimeout:   cfg_q.timeout    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_line_q <= s_axis_tdata_i[0];
      in_data_q <= s_axis_tdata_i[8:1];
    end
  end

  swdfe_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .cmd_i   (in_cmd_q),
    .line_i  (in_line_q),
    .data_i  (in_data_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Link state, updated once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= swdfe_pkg::PH_IDLE;
      state_q.kind      <= swdfe_pkg::KIND_TICK;
      state_q.bit_idx   <= '0;
      state_q.tick      <= '0;
      state_q.shift     <= '0;
      state_q.par       <= 1'b0;
      state_q.rx_byte   <= '0;
      state_q.prev_line <= 1'b1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q.rx_byte, res_q.status, res_q.done,
                            res_q.busy, res_q.drive_low};

endmodule

`default_nettype wire

FILE: hdl/swdfe_step.sv
`default_nettype none

// One tick of the frame engine: next state and result from the current
// state, the configuration and one input item.
module swdfe_step (
  input  swdfe_pkg::state_t  state_i,
  input  swdfe_pkg::cfg_t    cfg_i,
  input  logic [1:0]         cmd_i,
  input  logic               line_i,
  input  logic [7:0]         data_i,
  output swdfe_pkg::state_t  state_o,
  output swdfe_pkg::result_t res_o
);

  logic        fall;
  logic [15:0] tick_inc;
  // Sent bit timing.
  logic [15:0] tx_base;
  logic [15:0] tx_tc;
  logic        tx_bit;
  logic [7:0]  tx_low;
  logic        tx_drive;
  logic        tx_end;
  logic [3:0]  tx_idx_inc;
  logic [3:0]  tx_last;

  assign fall     = state_i.prev_line & ~line_i;
  assign tick_inc = (state_i.tick != swdfe_pkg::TickMax) ? state_i.tick + 16'd1 : state_i.tick;

  // A slot entered from the wait for a high line starts counting from zero.
  assign tx_base = (state_i.phase == swdfe_pkg::PH_TXWAIT) ? '0 : state_i.tick;
  assign tx_tc   = (tx_base != swdfe_pkg::TickMax) ? tx_base + 16'd1 : tx_base;

  always_comb begin
    if (state_i.kind == swdfe_pkg::KIND_RX) begin
      tx_bit = 1'b1;
    end else if (state_i.bit_idx == 4'd0) begin
      tx_bit = 1'b0;
    end else begin
      tx_bit = state_i.shift[8];
    end
  end

  assign tx_low     = tx_bit ? cfg_i.short_low : cfg_i.long_low;
  assign tx_drive   = tx_base < {8'd0, tx_low};
  assign tx_end     = (tx_tc >= {7'd0, cfg_i.bit_slot}) && (tx_tc >= {8'd0, tx_low});
  assign tx_idx_inc = state_i.bit_idx + 4'd1;
  assign tx_last    = (state_i.kind == swdfe_pkg::KIND_CMD) ? swdfe_pkg::CmdFrameBits
                                                            : swdfe_pkg::ByteFrameBits;

  // Phase sequencing.
  always_comb begin
    state_o        = state_i;
    res_o          = '0;
    res_o.status   = swdfe_pkg::ST_OK;

    unique case (state_i.phase) inside
      swdfe_pkg::PH_IDLE: begin
        if (cmd_i != swdfe_pkg::KIND_TICK) begin
          state_o.kind    = swdfe_pkg::kind_e'(cmd_i);
          state_o.bit_idx = '0;
          state_o.tick    = '0;
          state_o.par     = 1'b0;
          unique case (swdfe_pkg::kind_e'(cmd_i))
            swdfe_pkg::KIND_CMD: begin
              state_o.shift = {data_i[2:0], ^data_i[2:0], 5'd0};
              state_o.phase = swdfe_pkg::PH_TXWAIT;
            end
            swdfe_pkg::KIND_BYTE: begin
              state_o.shift = {data_i, ^data_i};
              state_o.phase = swdfe_pkg::PH_TXWAIT;
            end
            default: begin
              state_o.shift = '0;
              state_o.phase = swdfe_pkg::PH_RXWAIT;
            end
          endcase
        end
      end

      swdfe_pkg::PH_TXWAIT, swdfe_pkg::PH_TXBIT: begin
        if (state_i.phase == swdfe_pkg::PH_TXBIT || line_i) begin
          res_o.drive_low = tx_drive;
          if (!tx_end) begin
            state_o.phase = swdfe_pkg::PH_TXBIT;
            state_o.tick  = tx_tc;
          end else if (state_i.kind == swdfe_pkg::KIND_RX) begin
            // Acknowledge bit of a received frame is out.
            state_o.phase = swdfe_pkg::PH_IDLE;
            state_o.tick  = tx_tc;
            res_o.done    = 1'b1;
            res_o.status  = swdfe_pkg::ST_OK;
          end else begin
            if (state_i.bit_idx != 4'd0) begin
              state_o.shift = {state_i.shift[7:0], 1'b0};
            end
            state_o.bit_idx = tx_idx_inc;
            state_o.tick    = '0;
            state_o.phase   = (tx_idx_inc >= tx_last) ? swdfe_pkg::PH_ACKWAIT
                                                      : swdfe_pkg::PH_TXWAIT;
          end
        end
      end

      swdfe_pkg::PH_ACKWAIT, swdfe_pkg::PH_RXWAIT: begin
        if (fall) begin
          state_o.phase = (state_i.phase == swdfe_pkg::PH_ACKWAIT) ? swdfe_pkg::PH_ACKSAMP
                                                                   : swdfe_pkg::PH_RXSAMP;
          state_o.tick  = '0;
        end else begin
          state_o.tick = tick_inc;
          if (tick_inc >= cfg_i.timeout) begin
            state_o.phase = swdfe_pkg::PH_IDLE;
            res_o.done    = 1'b1;
            res_o.status  = swdfe_pkg::ST_TIMEOUT;
          end
        end
      end

      swdfe_pkg::PH_ACKSAMP: begin
        state_o.tick = tick_inc;
        if (tick_inc >= {8'd0, cfg_i.samp_delay}) begin
          state_o.phase = swdfe_pkg::PH_IDLE;
          res_o.done    = 1'b1;
          res_o.status  = line_i ? swdfe_pkg::ST_OK : swdfe_pkg::ST_NACK;
        end
      end

      swdfe_pkg::PH_RXSAMP: begin
        state_o.tick = tick_inc;
        if (tick_inc >= {8'd0, cfg_i.samp_delay}) begin
          state_o.tick = '0;
          if (state_i.bit_idx == 4'd0) begin
            // Header of a target frame must be a one.
            if (!line_i) begin
              state_o.phase = swdfe_pkg::PH_IDLE;
              res_o.done    = 1'b1;
              res_o.status  = swdfe_pkg::ST_BAD_HDR;
            end else begin
              state_o.bit_idx = 4'd1;
              state_o.phase   = swdfe_pkg::PH_RXWAIT;
            end
          end else if (state_i.bit_idx <= swdfe_pkg::RxLastDataIdx) begin
            state_o.shift   = {state_i.shift[7:0], line_i};
            state_o.par     = state_i.par ^ line_i;
            state_o.bit_idx = tx_idx_inc;
            state_o.phase   = swdfe_pkg::PH_RXWAIT;
          end else if (line_i != state_i.par) begin
            state_o.phase = swdfe_pkg::PH_IDLE;
            res_o.done    = 1'b1;
            res_o.status  = swdfe_pkg::ST_PARITY;
          end else begin
            state_o.rx_byte = state_i.shift[7:0];
            state_o.phase   = (cfg_i.ack_gap == 8'd0) ? swdfe_pkg::PH_TXWAIT
                                                      : swdfe_pkg::PH_GAP;
          end
        end
      end

      swdfe_pkg::PH_GAP: begin
        state_o.tick = tick_inc;
        if (tick_inc >= {8'd0, cfg_i.ack_gap}) begin
          state_o.phase = swdfe_pkg::PH_TXWAIT;
          state_o.tick  = '0;
        end
      end
    endcase

    state_o.prev_line = line_i;
    res_o.busy        = (state_o.phase != swdfe_pkg::PH_IDLE);
    res_o.rx_byte     = state_o.rx_byte;
  end

endmodule

`default_nettype wire

FILE: hdl/swdfe_checker.sv
`default_nettype none

// Port-level checks of the frame engine.
module swdfe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // With no result pending, the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // A finished frame leaves the engine idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2] |-> !m_axis_tdata_o[1])
    else $error("done reported while still busy");

  // Status is only reported on a finishing item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[2] |-> m_axis_tdata_o[5:3] == 3'd0)
    else $error("status without done");

endmodule

bind single_wire_debug_frame_engine_unit swdfe_checker u_swdfe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
